// ===== hdl/ils_pkg.sv =====
package ils_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CNTO_W = 7;

  // Default list depth
  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_HEAD   = 3'd1,
    CMD_TAIL   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4
  } ils_cmd_e;

  // What a decoded command will do to the list
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_READ,
    KIND_INSERT,
    KIND_DELETE
  } ils_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_COMMIT,
    ST_READ,
    ST_FINISH
  } ils_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic decode;
    logic shift_rd;
    logic shift_wr;
    logic commit;
    logic rd_elem;
    logic load_res;
  } ils_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    ils_kind_e kind;
    logic      more;
    logic      res_free;
  } ils_sts_t;

endpackage

// ===== hdl/ils_if.sv =====
interface ils_cmd_if;
  import ils_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface ils_res_if;
  import ils_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic                    read_valid;
  logic                    accepted;
  logic [CNTO_W-1:0]       entry_count;

  modport source (output valid, read_value, read_valid, accepted, entry_count,
                  input ready);
  modport sink   (input valid, read_value, read_valid, accepted, entry_count,
                  output ready);
endinterface

// ===== hdl/ils_ctrl.sv =====
module ils_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ils_pkg::ils_sts_t sts_i,
  output ils_pkg::ils_ctl_t ctl_o
);
  import ils_pkg::*;

  ils_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.take = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctl_o.decode = 1'b1;
        unique case (sts_i.kind)
          KIND_READ:   state_d = ST_READ;
          KIND_INSERT,
          KIND_DELETE: state_d = ST_SHIFT_RD;
          default:     state_d = ST_FINISH;
        endcase
      end
      ST_SHIFT_RD: begin
        if (sts_i.more) begin
          ctl_o.shift_rd = 1'b1;
          state_d        = ST_SHIFT_WR;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_SHIFT_WR: begin
        ctl_o.shift_wr = 1'b1;
        state_d        = ST_SHIFT_RD;
      end
      ST_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_READ: begin
        ctl_o.rd_elem = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        // Wait for the output register to free up
        if (sts_i.res_free) begin
          ctl_o.load_res = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/ils_dp.sv =====
module ils_dp #(
  parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ils_pkg::ils_ctl_t               ctl_i,
  output ils_pkg::ils_sts_t               sts_o,
  input  logic [ils_pkg::CMD_W-1:0]       command_i,
  input  logic [ils_pkg::POS_W-1:0]       position_i,
  input  logic signed [ils_pkg::VAL_W-1:0] value_i,
  input  logic                            res_ready_i,
  output logic                            res_valid_o,
  output logic signed [ils_pkg::VAL_W-1:0] read_value_o,
  output logic                            read_valid_o,
  output logic                            accepted_o,
  output logic [ils_pkg::CNTO_W-1:0]      entry_count_o
);
  import ils_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned WW = CW + POS_W;
  localparam logic [CW-1:0] ONE_C  = CW'(1);
  localparam logic [CW-1:0] FULL_C = CW'(CAPACITY);

  // Element store
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic signed [VAL_W-1:0] mem_wd;
  logic                    mem_re;
  logic [AW-1:0]           mem_ra;
  logic signed [VAL_W-1:0] rdata_q;

  // Latched command and working registers
  logic [CMD_W-1:0]        cmd_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           k_q, k_d;
  logic [CW-1:0]           tgt_q, tgt_d;
  ils_kind_e               kind_q, kind_d;
  logic                    is_rd_q;

  // Output register
  logic                    res_valid_q;
  logic signed [VAL_W-1:0] res_value_q;
  logic                    res_rvalid_q;
  logic                    res_acc_q;
  logic [CNTO_W-1:0]       res_count_q;

  logic [WW-1:0]   pos_w, cnt_w;
  logic            full;
  logic [CW:0]     k_inc_w;
  logic [WW+CNTO_W-1:0] cnt_ow;

  assign pos_w   = {{CW{1'b0}}, pos_q};
  assign cnt_w   = {{POS_W{1'b0}}, count_q};
  assign full    = (count_q == FULL_C);
  assign k_inc_w = {1'b0, k_q} + {1'b0, ONE_C};

  // Decode the latched command against the current count
  always_comb begin
    kind_d = KIND_NONE;
    tgt_d  = '0;
    unique case (cmd_q)
      CMD_READ: begin
        if (pos_w < cnt_w) kind_d = KIND_READ;
      end
      CMD_HEAD: begin
        if (!full) kind_d = KIND_INSERT;
      end
      CMD_TAIL: begin
        if (!full) kind_d = KIND_INSERT;
        tgt_d = count_q;
      end
      CMD_INSERT: begin
        if (!full && pos_w <= cnt_w) kind_d = KIND_INSERT;
        tgt_d = pos_w[CW-1:0];
      end
      CMD_DELETE: begin
        if (pos_w < cnt_w) kind_d = KIND_DELETE;
        tgt_d = pos_w[CW-1:0];
      end
      default: kind_d = KIND_NONE;
    endcase
  end

  // Status to the controller
  always_comb begin
    sts_o.kind     = kind_d;
    sts_o.res_free = !res_valid_q || res_ready_i;
    if (kind_q == KIND_INSERT) begin
      sts_o.more = (k_q > tgt_q);
    end else begin
      sts_o.more = (k_inc_w < {1'b0, count_q});
    end
  end

  // Memory port selection and pointer/count updates
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = k_q[AW-1:0];
    mem_wd  = rdata_q;
    mem_re  = 1'b0;
    mem_ra  = pos_w[AW-1:0];
    k_d     = k_q;
    count_d = count_q;
    if (ctl_i.decode) begin
      k_d = (kind_d == KIND_INSERT) ? count_q : tgt_d;
    end
    if (ctl_i.rd_elem) begin
      mem_re = 1'b1;
    end
    if (ctl_i.shift_rd) begin
      mem_re = 1'b1;
      if (kind_q == KIND_INSERT) begin
        mem_ra = k_q[AW-1:0] - AW'(1);
      end else begin
        mem_ra = k_inc_w[AW-1:0];
      end
    end
    if (ctl_i.shift_wr) begin
      mem_we = 1'b1;
      k_d    = (kind_q == KIND_INSERT) ? (k_q - ONE_C) : k_inc_w[CW-1:0];
    end
    if (ctl_i.commit) begin
      if (kind_q == KIND_INSERT) begin
        mem_we  = 1'b1;
        mem_wa  = tgt_q[AW-1:0];
        mem_wd  = val_q;
        count_d = count_q + ONE_C;
      end else begin
        count_d = count_q - ONE_C;
      end
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  // Capture the incoming word and decode results
  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      cmd_q <= command_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (ctl_i.decode) begin
      tgt_q   <= tgt_d;
      is_rd_q <= (cmd_q == CMD_READ);
    end
    k_q <= k_d;
  end

  // Control state: count and decoded kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      kind_q  <= KIND_NONE;
    end else begin
      count_q <= count_d;
      if (ctl_i.decode) kind_q <= kind_d;
    end
  end

  assign cnt_ow = {{(WW+CNTO_W-CW){1'b0}}, count_q};

  // Result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ctl_i.load_res) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_res) begin
      res_rvalid_q <= (kind_q == KIND_READ);
      res_acc_q    <= (kind_q != KIND_NONE);
      res_count_q  <= cnt_ow[CNTO_W-1:0];
      if (kind_q == KIND_READ) begin
        res_value_q <= rdata_q;
      end else if (is_rd_q) begin
        res_value_q <= '1;
      end else begin
        res_value_q <= '0;
      end
    end
  end

  assign res_valid_o   = res_valid_q;
  assign read_value_o  = res_value_q;
  assign read_valid_o  = res_rvalid_q;
  assign accepted_o    = res_acc_q;
  assign entry_count_o = res_count_q;

endmodule

// ===== hdl/indexed_list_store.sv =====
// Ordered list of signed 32-bit values held in a CAPACITY-deep memory with
// one write and one registered read port. A command word is taken only while
// the controller is idle; a finished result waits in an output register, so
// the next word can be taken before the previous result is drained. Inserts
// and deletes move every later entry by one place through the single memory
// read/write port pair, with a read state and a write state per moved entry.
// The controller returns to idle as the result is loaded and can take the next
// word in the cycle after; while an earlier result still sits undrained in the
// output register, the finished command holds until that register frees up.
// Inserts are refused (accepted low) when the list is full; entry_count reports
// the low seven bits of the count after the command.
module indexed_list_store #(
  parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ils_cmd_if.sink   cmd_i,
  ils_res_if.source res_o
);
  import ils_pkg::*;

  ils_ctl_t ctl;
  ils_sts_t sts;

  ils_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ils_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .command_i     (cmd_i.command),
    .position_i    (cmd_i.position),
    .value_i       (cmd_i.value),
    .res_ready_i   (res_o.ready),
    .res_valid_o   (res_o.valid),
    .read_value_o  (res_o.read_value),
    .read_valid_o  (res_o.read_valid),
    .accepted_o    (res_o.accepted),
    .entry_count_o (res_o.entry_count)
  );

endmodule

// ===== test/tb_indexed_list_store.sv =====
`timescale 1ns / 1ps

module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DEF;
  localparam int unsigned RANDOM_WORDS = 1130;
  localparam int unsigned PHASE_LEN    = 100;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned TAIL_CYCLES  = 2 * CAPACITY + 16;

  // Command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = CMD_W'(int'(CMD_DELETE) + 1);
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = '1;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic                    read_valid;
    logic                    accepted;
    logic [CNTO_W-1:0]       entry_count;
  } list_result_t;

  // Shadow copy of the list plus the queue of results still owed by the block
  class list_scoreboard;
    logic signed [VAL_W-1:0] shadow_list[$];
    list_result_t            expected_q[$];
    int unsigned             results_checked;
    int unsigned             errors;

    function int unsigned fill();
      return shadow_list.size();
    endfunction

    // Apply one accepted command word to the shadow list and queue its result
    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val);
      list_result_t res;
      int unsigned  count;
      int unsigned  slot;
      count          = shadow_list.size();
      slot           = 32'(pos);
      res.read_value = '0;
      res.read_valid = 1'b0;
      res.accepted   = 1'b0;
      case (cmd)
        CMD_READ: begin
          if (slot < count) begin
            res.read_value = shadow_list[slot];
            res.read_valid = 1'b1;
            res.accepted   = 1'b1;
          end else begin
            res.read_value = '1;
          end
        end
        CMD_HEAD, CMD_TAIL, CMD_INSERT: begin
          if (cmd == CMD_HEAD) slot = 0;
          else if (cmd == CMD_TAIL) slot = count;
          // refuse when full or when the index lies past the end
          if (count < CAPACITY && slot <= count) begin
            shadow_list.insert(slot, val);
            res.accepted = 1'b1;
          end
        end
        CMD_DELETE: begin
          if (slot < count) begin
            shadow_list.delete(slot);
            res.accepted = 1'b1;
          end
        end
        default: ;
      endcase
      res.entry_count = CNTO_W'(shadow_list.size());
      expected_q.insert(expected_q.size(), res);
    endfunction

    task report_mismatch(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] seen);
      $display("%0t: result %0d %s: expected 0x%0h, got 0x%0h",
               $time, results_checked, what, want, seen);
      errors++;
    endtask

    // Compare one result word against the oldest expectation
    task check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("arrived with nothing outstanding", '0, got.read_value);
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        if (got.read_value !== want.read_value)
          report_mismatch("read_value", want.read_value, got.read_value);
        if (got.read_valid !== want.read_valid)
          report_mismatch("read_valid", VAL_W'(want.read_valid),
                          VAL_W'(got.read_valid));
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", VAL_W'(want.accepted), VAL_W'(got.accepted));
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", VAL_W'(want.entry_count),
                          VAL_W'(got.entry_count));
      end
      results_checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  ils_cmd_if cmd_if ();
  ils_res_if res_if ();

  list_scoreboard sb = new();
  int unsigned    burst_left = 0;

  indexed_list_store #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offer one command word, inserting a random gap between bursts
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    if (burst_left == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= cmd;
    cmd_if.position <= pos;
    cmd_if.value    <= val;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(cmd, pos, val);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range commands, weighted to grow, churn or shrink the list
  task automatic send_random_word(input int unsigned phase);
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    int unsigned      count;
    int unsigned      roll;
    int unsigned      read_w;
    int unsigned      insert_w;
    count = sb.fill();
    case (phase % 4)
      0:       begin read_w = 6;  insert_w = 88; end
      2:       begin read_w = 10; insert_w = 5;  end
      default: begin read_w = 40; insert_w = 30; end
    endcase
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 15) begin
      cmd = CMD_W'($urandom_range(0, 7));
      pos = POS_W'($urandom_range(0, 127));
    end else if (roll < read_w) begin
      cmd = CMD_READ;
      pos = (count == 0) ? '0 : POS_W'($urandom_range(0, count - 1));
    end else if (roll < read_w + insert_w) begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_HEAD;
        1:       cmd = CMD_TAIL;
        default: cmd = CMD_INSERT;
      endcase
      pos = (cmd == CMD_INSERT) ? POS_W'($urandom_range(0, count))
                                : POS_W'($urandom_range(0, 127));
    end else begin
      cmd = CMD_DELETE;
      pos = (count == 0) ? '0 : POS_W'($urandom_range(0, count - 1));
    end
    send_word(cmd, pos, pick_value());
  endtask

  // Main sequence: reset, directed words, random words, drain, verdict
  initial begin
    cmd_if.valid    <= 1'b0;
    cmd_if.command  <= CMD_READ;
    cmd_if.position <= '0;
    cmd_if.value    <= '0;
    rst_ni          <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: reads miss, delete and past-end insert are refused
    send_word(CMD_READ, '0, '0);
    send_word(CMD_READ, '1, '1);
    send_word(CMD_DELETE, '0, '0);
    send_word(CMD_INSERT, 7'd1, 32'h1234_5678);
    // build the list from both ends and the middle
    send_word(CMD_HEAD, '1, VAL_MIN);
    send_word(CMD_TAIL, '0, VAL_MAX);
    send_word(CMD_INSERT, '0, '1);
    send_word(CMD_INSERT, 7'd3, '0);
    send_word(CMD_INSERT, 7'd5, 32'hAAAA_AAAA);
    send_word(CMD_INSERT, 7'd2, 32'h5555_5555);
    for (int i = 0; i <= 5; i++) send_word(CMD_READ, POS_W'(i), '0);
    // undefined codes leave the list alone
    for (int c = CMD_UNDEF_LO; c <= CMD_UNDEF_HI; c++) send_word(CMD_W'(c), '1, '1);
    // delete the last and the first entry, then one past the end
    send_word(CMD_DELETE, 7'd4, '0);
    send_word(CMD_DELETE, '0, '0);
    send_word(CMD_DELETE, 7'd3, '0);
    send_word(CMD_READ, 7'd64, '0);
    drain_results();

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      send_random_word(n / PHASE_LEN);
      if (n == 400 || n == 900) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_indexed_list_store passed");
    end else begin
      $display("tb_indexed_list_store failed");
    end
    $finish;
  end

  // Result side: check accepted words and stall on a pattern of its own
  initial begin
    int unsigned  seg_left;
    int unsigned  seg_kind;
    int unsigned  hold_left;
    int unsigned  seen;
    logic         take;
    list_result_t got;
    seg_left  = 0;
    seg_kind  = 0;
    hold_left = 0;
    seen      = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        got.read_value  = res_if.read_value;
        got.read_valid  = res_if.read_valid;
        got.accepted    = res_if.accepted;
        got.entry_count = res_if.entry_count;
        sb.check_result(got);
        seen++;
        // long hold-off so the block backs up into its command port
        if (seen == 300 || seen == 800) hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_kind = $urandom_range(0, 2);
        seg_left = $urandom_range(10, 150);
      end
      seg_left--;
      if (hold_left != 0) begin
        take = 1'b0;
        hold_left--;
      end else begin
        case (seg_kind)
          0:       take = 1'b1;
          1:       take = $urandom_range(0, 1);
          default: take = ($urandom_range(0, 4) == 0);
        endcase
      end
      res_if.ready <= take;
    end
  end

  // Watchdog: stop when no word moves on either side for too long
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) idle = 0;
      else idle++;
    end
    $display("tb_indexed_list_store failed");
    $finish;
  end

endmodule
